/* design/tli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared widths, request codes and arithmetic limits of the interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

	// Data word and fixed-point format (signed Q16.16).
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_LOAD_X = 2'd0;
	localparam logic [1:0] REQ_LOAD_Y = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	// Slope and result limits.
	localparam logic signed [31:0] SLOPE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SLOPE_MIN = -32'sh7FFF_FFFF;
	localparam logic [31:0]        DATA_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0]        DATA_MIN  = 32'h8000_0000;

	typedef logic [DATA_W-1:0] word_t;

endpackage

/* design/tli_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and registered read with data the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/table_linear_interpolator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table linear interpolator
// Piecewise linear lookup over a loaded table of x points and y columns.
// ----------------------------------------------------------------------------
// Loads (x point or y value) are written when accepted and keep busy low.
// A query holds busy high while it runs. The end-row range test reads the
// first x point, then compares against each end row in turn; an out-of-range
// query skips the search. The binary search over the x store reads and then
// compares at each probe, with at most ceil(log2(rows-1)) probes, and a final
// step closes the search. Each column then reads the y store and, in range,
// has a slope set-up step, the shared shift-subtract divider (skipped for a
// zero or saturating dx), a multiply step and a result step. Out of range,
// the result is taken from the y store read directly. Each result is shown for
// exactly one cycle with valid high, in the cycle after its column finishes,
// so the last one appears in the first cycle with busy low. The receiver
// cannot stall the block: results must be taken as they come.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic signed [31:0] data_value,
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	// Result channel
	output logic        valid,
	output logic [2:0]  out_col,
	output logic signed [31:0] interp_value,
	output logic        in_range,
	output logic signed [31:0] query_echo,
	output logic        last_col
);

	localparam int XAW = $clog2(MAX_ROWS);
	localparam int YAW = $clog2(MAX_ROWS * MAX_COLS);
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_X0       = 4'd1;
	localparam logic [3:0] S_X0_CMP   = 4'd2;
	localparam logic [3:0] S_XL_CMP   = 4'd3;
	localparam logic [3:0] S_SRCH     = 4'd4;
	localparam logic [3:0] S_SRCH_CMP = 4'd5;
	localparam logic [3:0] S_YA       = 4'd6;
	localparam logic [3:0] S_YB       = 4'd7;
	localparam logic [3:0] S_YW       = 4'd8;
	localparam logic [3:0] S_DIV      = 4'd9;
	localparam logic [3:0] S_MUL      = 4'd10;
	localparam logic [3:0] S_FIN      = 4'd11;

	logic [3:0] state_q;
	logic [8:0] num_rows_q;
	logic [3:0] num_cols_q;

	logic signed [31:0] xq_q, xlo_q, xhi_q, ya_q, slope_q;
	logic signed [32:0] dx_q, off_q;
	logic signed [64:0] prod_q;
	logic [XAW-1:0] lo_q, hi_q;
	logic [CW-1:0]  j_q;
	logic           inr_q, neg_q;
	logic [47:0]    rem_q;
	logic [61:0]    dsh_q;
	logic [30:0]    quo_q;
	logic [4:0]     cnt_q;

	logic        valid_q, in_range_q, last_q;
	logic [2:0]  out_col_q;
	logic [31:0] interp_q, echo_q;

	// Effective row and column limits from the configuration.
	logic [31:0]    nr_m1, nc_m1, j_ext;
	logic [XAW-1:0] last_row;
	logic [CW-1:0]  last_c;
	always_comb begin
		if (num_rows_q < 9'd2) begin
			nr_m1 = 32'd1;
		end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
			nr_m1 = 32'(MAX_ROWS) - 32'd1;
		end else begin
			nr_m1 = 32'(num_rows_q) - 32'd1;
		end
		if (num_cols_q == 4'd0) begin
			nc_m1 = 32'd0;
		end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
			nc_m1 = 32'(MAX_COLS) - 32'd1;
		end else begin
			nc_m1 = 32'(num_cols_q) - 32'd1;
		end
		last_row = XAW'(nr_m1);
		last_c   = CW'(nc_m1);
		j_ext    = 32'(j_q);
	end

	// Command acceptance and load writes.
	logic accept, x_we, y_we;
	assign accept = start && !busy;
	assign x_we = accept && (req_type == tli_pkg::REQ_LOAD_X)
		&& (32'(row_index) < 32'(MAX_ROWS));
	assign y_we = accept && (req_type == tli_pkg::REQ_LOAD_Y)
		&& (32'(row_index) < 32'(MAX_ROWS)) && (32'(col_index) < 32'(MAX_COLS));

	logic [XAW-1:0] x_waddr, x_raddr, mid, y_row;
	logic [YAW-1:0] y_waddr, y_raddr;
	tli_pkg::word_t x_rdata, y_rdata;

	assign x_waddr = XAW'(32'(row_index));
	assign y_waddr = YAW'(32'(row_index) * MAX_COLS + 32'(col_index));
	assign mid = XAW'(({1'b0, hi_q} + {1'b0, lo_q}) >> 1);

	// Read address selection for both stores.
	always_comb begin
		unique case (state_q)
			S_X0_CMP: x_raddr = last_row;
			S_SRCH:   x_raddr = mid;
			default:  x_raddr = '0;
		endcase
		y_row   = (state_q == S_YB) ? lo_q + XAW'(1) : lo_q;
		y_raddr = YAW'(32'(y_row) * MAX_COLS + j_ext);
	end

	tli_ram #(.WIDTH(tli_pkg::DATA_W), .DEPTH(MAX_ROWS)) u_x_ram (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(data_value),
		.raddr(x_raddr), .rdata(x_rdata)
	);

	tli_ram #(.WIDTH(tli_pkg::DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_y_ram (
		.clk(clk), .we(y_we), .waddr(y_waddr), .wdata(data_value),
		.raddr(y_raddr), .rdata(y_rdata)
	);

	// Datapath helpers for slope set-up, division step and final sum.
	logic signed [32:0] dy;
	logic [31:0] dy_abs, dx_abs;
	logic [47:0] num_abs;
	logic        div_take;
	logic [30:0] quo_nx;
	logic signed [49:0] sum;
	logic [31:0] sum_sat;
	always_comb begin
		dy       = $signed({y_rdata[31], y_rdata}) - $signed({ya_q[31], ya_q});
		dy_abs   = dy[32] ? 32'(-dy) : dy[31:0];
		dx_abs   = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
		num_abs  = {dy_abs, 16'd0};
		div_take = {14'd0, rem_q} >= dsh_q;
		quo_nx   = {quo_q[29:0], div_take};
		sum      = $signed(prod_q[64:16]) + $signed(ya_q);
		if (sum[49:31] != {19{sum[49]}}) begin
			sum_sat = sum[49] ? tli_pkg::DATA_MIN : tli_pkg::DATA_MAX;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 9'd2;
			num_cols_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tli_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data;
				tli_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:     if (accept && req_type == tli_pkg::REQ_QUERY) state_q <= S_X0;
				S_X0:       state_q <= S_X0_CMP;
				S_X0_CMP:   state_q <= ($signed(xq_q) < $signed(x_rdata)) ? S_YA : S_XL_CMP;
				S_XL_CMP:   state_q <= ($signed(xq_q) > $signed(x_rdata)) ? S_YA : S_SRCH;
				S_SRCH:     state_q <= ((hi_q - lo_q) > XAW'(1)) ? S_SRCH_CMP : S_YA;
				S_SRCH_CMP: state_q <= S_SRCH;
				S_YA:       state_q <= S_YB;
				S_YB: begin
					if (inr_q) begin
						state_q <= S_YW;
					end else begin
						valid_q <= 1'b1;
						state_q <= (j_q == last_c) ? S_IDLE : S_YA;
					end
				end
				S_YW: begin
					if (dx_q == 33'sd0 || {16'd0, num_abs} >= {1'b0, dx_abs, 31'd0}) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV:      if (cnt_q == 5'd0) state_q <= S_MUL;
				S_MUL:      state_q <= S_FIN;
				S_FIN: begin
					valid_q <= 1'b1;
					state_q <= (j_q == last_c) ? S_IDLE : S_YA;
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xq_q <= data_value;
				j_q  <= '0;
			end
			S_X0_CMP: begin
				xlo_q <= x_rdata;
				lo_q  <= '0;
				inr_q <= 1'b0;
			end
			S_XL_CMP: begin
				xhi_q <= x_rdata;
				hi_q  <= last_row;
				if ($signed(xq_q) > $signed(x_rdata)) begin
					lo_q <= last_row;
				end else begin
					inr_q <= 1'b1;
				end
			end
			S_SRCH: begin
				dx_q  <= $signed({xhi_q[31], xhi_q}) - $signed({xlo_q[31], xlo_q});
				off_q <= $signed({xq_q[31], xq_q}) - $signed({xlo_q[31], xlo_q});
			end
			S_SRCH_CMP: begin
				if ($signed(xq_q) < $signed(x_rdata)) begin
					hi_q  <= mid;
					xhi_q <= x_rdata;
				end else begin
					lo_q  <= mid;
					xlo_q <= x_rdata;
				end
			end
			S_YB: begin
				ya_q <= y_rdata;
				if (!inr_q) begin
					out_col_q  <= j_ext[2:0];
					interp_q   <= y_rdata;
					in_range_q <= 1'b0;
					echo_q     <= xq_q;
					last_q     <= (j_q == last_c);
					j_q        <= j_q + CW'(1);
				end
			end
			S_YW: begin
				neg_q <= dy[32] ^ dx_q[32];
				rem_q <= num_abs;
				dsh_q <= {dx_abs, 30'd0};
				quo_q <= '0;
				cnt_q <= 5'd30;
				if (dx_q == 33'sd0) begin
					slope_q <= (dy > 33'sd0) ? tli_pkg::SLOPE_MAX
						: ((dy < 33'sd0) ? tli_pkg::SLOPE_MIN : 32'sd0);
				end else begin
					slope_q <= (dy[32] ^ dx_q[32]) ? tli_pkg::SLOPE_MIN : tli_pkg::SLOPE_MAX;
				end
			end
			S_DIV: begin
				if (div_take) begin
					rem_q <= rem_q - dsh_q[47:0];
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					slope_q <= neg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
				end
			end
			S_MUL: begin
				prod_q <= $signed(slope_q) * $signed(off_q);
			end
			S_FIN: begin
				out_col_q  <= j_ext[2:0];
				interp_q   <= sum_sat;
				in_range_q <= 1'b1;
				echo_q     <= xq_q;
				last_q     <= (j_q == last_c);
				j_q        <= j_q + CW'(1);
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign valid        = valid_q;
	assign out_col      = out_col_q;
	assign interp_value = interp_q;
	assign in_range     = in_range_q;
	assign query_echo   = echo_q;
	assign last_col     = valid_q & last_q;

`ifndef NO_ASSERTIONS
	// A result only follows a cycle in which a query was running.
	a_valid_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result without a running query");

	// An accepted query makes the block busy.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == tli_pkg::REQ_QUERY) |=> busy)
		else $error("query accepted but block not busy");

	// A result that is not the last one leaves the query running.
	a_more_cols: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last_col) |-> busy)
		else $error("query ended before its last column");

	// The last result of a query releases the block.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_col) |-> !busy)
		else $error("block still busy after the last column");
`endif

endmodule

/* sim/tb_table_linear_interpolator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the table linear interpolator
// Loads tables of x points and y columns, queries them and checks every
// column result against a cycle-free predictor of the interpolation, under
// several row and column settings and with random gaps on the command side.
// ----------------------------------------------------------------------------
module tb_table_linear_interpolator_unit;

	localparam int  ROWS_CAP   = 256;
	localparam int  COLS_CAP   = 8;
	localparam int  NUM_PH     = 9;
	localparam int  STALL_MAX  = 6000;
	localparam int  SETTLE_CYC = 400;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam longint LIM = 64'sd2147483647;

	typedef struct packed {
		logic [2:0]  col;
		logic [31:0] value;
		logic        inr;
		logic [31:0] echo;
		logic        last;
	} interp_res_t;

	// Scoreboard: holds the table copy, the register copy and the results due.
	class interp_scoreboard;
		longint      xs [ROWS_CAP];
		longint      ys [ROWS_CAP*COLS_CAP];
		int unsigned rows_reg;
		int unsigned cols_reg;
		interp_res_t due [$];
		int          errors;
		int          queries;
		int          results;

		function new();
			rows_reg = 2;
			cols_reg = 1;
			errors   = 0;
			queries  = 0;
			results  = 0;
			foreach (xs[i]) xs[i] = 0;
			foreach (ys[i]) ys[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [8:0] val);
			if (idx == tli_pkg::CFG_NUM_ROWS) rows_reg = val;
			else cols_reg = val[3:0];
		endfunction

		function longint lerp(longint xq, longint xa, longint xb, longint ya, longint yb);
			longint dy, dx, off, slope, r;
			dy  = yb - ya;
			dx  = xb - xa;
			off = xq - xa;
			if (dx == 0) begin
				slope = (dy > 0) ? LIM : ((dy < 0) ? -LIM : 0);
			end else begin
				slope = (dy * 65536) / dx;
				if (slope > LIM) slope = LIM;
				if (slope < -LIM) slope = -LIM;
			end
			r = ((slope * off) >>> 16) + ya;
			if (r > LIM) r = LIM;
			if (r < -LIM - 1) r = -LIM - 1;
			return r;
		endfunction

		// Note one accepted transaction and queue the results it causes.
		function void note_input(logic [1:0] req, logic [7:0] row, logic [2:0] col,
				logic signed [31:0] val);
			int unsigned nr, nc, k, lo, hi, mid;
			longint xq, r;
			bit inr;
			interp_res_t res;
			if (req == tli_pkg::REQ_LOAD_X) begin
				xs[row] = val;
				return;
			end
			if (req == tli_pkg::REQ_LOAD_Y) begin
				ys[row*COLS_CAP + col] = val;
				return;
			end
			if (req != tli_pkg::REQ_QUERY) return;
			queries++;
			nr = (rows_reg < 2) ? 2 : ((rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg);
			nc = (cols_reg < 1) ? 1 : ((cols_reg > COLS_CAP) ? COLS_CAP : cols_reg);
			xq = val;
			k = 0;
			if (xq < xs[0]) begin
				inr = 0;
			end else if (xq > xs[nr-1]) begin
				inr = 0;
				k = nr - 1;
			end else begin
				inr = 1;
				lo = 0;
				hi = nr - 1;
				while (hi - lo > 1) begin
					mid = (lo + hi) / 2;
					if (xq < xs[mid]) hi = mid;
					else lo = mid;
				end
				k = lo;
			end
			for (int j = 0; j < nc; j++) begin
				if (inr)
					r = lerp(xq, xs[k], xs[k+1], ys[k*COLS_CAP + j], ys[(k+1)*COLS_CAP + j]);
				else
					r = ys[k*COLS_CAP + j];
				res.col   = j[2:0];
				res.value = r[31:0];
				res.inr   = inr;
				res.echo  = val;
				res.last  = (j + 1 == nc);
				due.push_back(res);
			end
		endfunction

		// Compare one result against the oldest one due.
		function void check_result(interp_res_t got);
			interp_res_t want;
			results++;
			if (due.size() == 0) begin
				$error("unexpected result: col %0d value %h", got.col, got.value);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.col !== want.col) begin
				$error("out_col: expected %0d, got %0d", want.col, got.col);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("interp_value: expected %h, got %h", want.value, got.value);
				errors++;
			end
			if (got.inr !== want.inr) begin
				$error("in_range: expected %b, got %b", want.inr, got.inr);
				errors++;
			end
			if (got.echo !== want.echo) begin
				$error("query_echo: expected %h, got %h", want.echo, got.echo);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_col: expected %b, got %b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [7:0]         row_index;
	logic [2:0]         col_index;
	logic signed [31:0] data_value;
	logic               cfg_we;
	logic               cfg_index;
	logic [8:0]         cfg_data;
	logic               valid;
	logic [2:0]         out_col;
	logic signed [31:0] interp_value;
	logic               in_range;
	logic signed [31:0] query_echo;
	logic               last_col;

	interp_scoreboard table_sb;
	int               gap_pct;
	int               stall_cnt;
	bit               y_set [ROWS_CAP*COLS_CAP];
	int               ph_rows [NUM_PH] = '{2, 0, 3, 5, 7, 1, 4, 3, 6};
	int               ph_cols [NUM_PH] = '{1, 0, 8, 3, 2, 15, 4, 0, 1};

	table_linear_interpolator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.row_index    (row_index),
		.col_index    (col_index),
		.data_value   (data_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid        (valid),
		.out_col      (out_col),
		.interp_value (interp_value),
		.in_range     (in_range),
		.query_echo   (query_echo),
		.last_col     (last_col)
	);

	// Clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result monitor: every strobed result is checked at the edge ending it.
	always @(posedge clk) begin
		if (arst_n && valid)
			table_sb.check_result('{out_col, interp_value, in_range, query_echo, last_col});
	end

	// Watchdog on cycles in which no transaction, result or write takes place.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid || cfg_we) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_MAX) begin
				$display("tb_table_linear_interpolator_unit: errors");
				$finish;
			end
		end
	end

	// Present one transaction and hold it until the block takes it.
	task automatic send(logic [1:0] req, logic [7:0] row, logic [2:0] col,
			logic signed [31:0] val);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start      = 1'b1;
		req_type   = req;
		row_index  = row;
		col_index  = col;
		data_value = val;
		do @(posedge clk); while (busy);
		table_sb.note_input(req, row, col, val);
		if (req == tli_pkg::REQ_LOAD_Y) y_set[row*COLS_CAP + col] = 1'b1;
	endtask

	// Stop sending and wait until every result due has arrived.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (table_sb.due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		table_sb.write_reg(idx, val);
	endtask

	function automatic int eff_rows(int r);
		return (r < 2) ? 2 : ((r > ROWS_CAP) ? ROWS_CAP : r);
	endfunction

	function automatic int eff_cols(int c);
		return (c < 1) ? 1 : ((c > COLS_CAP) ? COLS_CAP : c);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(3))
			0: return $urandom_range(2047) - 1024;
			1: return {16'($urandom_range(32767) - 16384), 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Load a fresh table: ascending, ascending with repeated points, or unordered.
	task automatic load_table(int nr, int nc, int shape);
		longint xv, stride;
		xv     = -64'sd2147483648 + $urandom_range(1 << 20);
		stride = 64'sd4294967295 / nr;
		if ($urandom_range(1)) stride = stride / 4096 + 1;
		for (int r = 0; r < nr; r++) begin
			if (shape == 2) send(tli_pkg::REQ_LOAD_X, 8'(r), 0, $urandom);
			else send(tli_pkg::REQ_LOAD_X, 8'(r), 0, xv[31:0]);
			if (!(shape == 1 && $urandom_range(2) == 0))
				xv = xv + 1 + longint'($urandom) % stride;
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (nr * nc <= 200 || !y_set[r*COLS_CAP + c])
					send(tli_pkg::REQ_LOAD_Y, 8'(r), 3'(c), rand_word());
	endtask

	// One query, in range most of the time.
	task automatic random_query(int nr);
		longint a, b, q;
		a = table_sb.xs[0];
		b = table_sb.xs[nr-1];
		case ($urandom_range(9))
			0: q = $urandom;
			1: q = table_sb.xs[$urandom_range(nr-1)];
			2: q = a - 1;
			3: q = b + 1;
			default: begin
				if (b > a) q = a + longint'({$urandom, $urandom} % 64'(b - a + 1));
				else q = a;
			end
		endcase
		send(tli_pkg::REQ_QUERY, 8'($urandom), 3'($urandom), q[31:0]);
	endtask

	initial begin
		int nr, nc;
		table_sb   = new();
		gap_pct    = 16;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = tli_pkg::REQ_LOAD_X;
		row_index  = '0;
		col_index  = '0;
		data_value = '0;
		cfg_we     = 1'b0;
		cfg_index  = tli_pkg::CFG_NUM_ROWS;
		cfg_data   = '0;
		foreach (y_set[i]) y_set[i] = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, widest x span with extreme y values.
		send(tli_pkg::REQ_LOAD_X, 0, 0, 32'sh8000_0000);
		send(tli_pkg::REQ_LOAD_X, 1, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_LOAD_Y, 0, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_LOAD_Y, 1, 0, 32'sh8000_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh8000_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0000_0000);
		send(REQ_NONE, 8'hFF, 3'h7, 32'sh1234_5678);
		// Steep slope that saturates, then a coinciding pair of x points.
		send(tli_pkg::REQ_LOAD_X, 1, 0, 32'sh8000_0001);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh8000_0001);
		send(tli_pkg::REQ_LOAD_X, 0, 0, 32'sh0005_0000);
		send(tli_pkg::REQ_LOAD_X, 1, 0, 32'sh0005_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0005_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0004_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0006_0000);
		send(tli_pkg::REQ_LOAD_Y, 1, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0005_0000);
		send(tli_pkg::REQ_LOAD_Y, 1, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_LOAD_Y, 0, 0, 32'sh7FFF_FFFF);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0005_0000);
		// Descending pair: an unordered table.
		send(tli_pkg::REQ_LOAD_X, 0, 0, 32'sh0008_0000);
		send(tli_pkg::REQ_LOAD_X, 1, 0, -32'sh0008_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0000_0000);
		send(tli_pkg::REQ_QUERY, 0, 0, 32'sh0009_0000);
		drain();

		// Phases over the register settings, clamped values among them.
		for (int ph = 0; ph < NUM_PH; ph++) begin
			gap_pct = (ph < 3) ? 16 : ((ph < 6) ? 84 : 0);
			nr = eff_rows(ph_rows[ph]);
			nc = eff_cols(ph_cols[ph]);
			write_reg(tli_pkg::CFG_NUM_ROWS, 9'(ph_rows[ph]));
			write_reg(tli_pkg::CFG_NUM_COLS, 9'(ph_cols[ph]));
			load_table(nr, nc, ph % 3);
			for (int q = 0; q < 8; q++) begin
				case ($urandom_range(9))
					0: send(tli_pkg::REQ_LOAD_Y, 8'($urandom_range(nr-1)),
						3'($urandom_range(nc-1)), rand_word());
					1: send(REQ_NONE, 8'($urandom), 3'($urandom), $urandom);
					2: send(tli_pkg::REQ_LOAD_X, 8'($urandom_range(nr-1)), 3'($urandom),
						rand_word());
					default: random_query(nr);
				endcase
			end
			// After each phase the sender waits for the block to empty.
			drain();
		end

		for (int i = 0; i < SETTLE_CYC && table_sb.due.size() != 0; i++) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		$display("Covered %0d queries and %0d column results over %0d table settings,",
			table_sb.queries, table_sb.results, NUM_PH);
		$display("with ordered, repeated-point and unordered tables and clamped registers.");
		if (table_sb.errors == 0 && table_sb.due.size() == 0) begin
			$display("tb_table_linear_interpolator_unit: clean");
		end else begin
			if (table_sb.due.size() != 0)
				$error("%0d expected results never arrived", table_sb.due.size());
			$display("tb_table_linear_interpolator_unit: errors");
		end
		$finish;
	end

endmodule
